// ===== rtl/rtab_pkg.sv =====
// Shared types and constants for the record table.
`timescale 1ns / 1ps

package rtab_pkg;

	localparam int KEY_W = 16;
	localparam int VAL_W = 16;
	localparam int REC_W = KEY_W + VAL_W;
	localparam int CNT_OUT_W = 7;

	typedef enum logic [2:0] {
		OP_APPEND = 3'd0,
		OP_SEARCH = 3'd1,
		OP_DELETE = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_COUNT  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	// Completion of one request, handed from the sequencer to the result register.
	typedef struct packed {
		logic               done;
		status_t            status;
		logic [VAL_W-1:0]   found_inventory;
	} fin_t;

endpackage

// ===== rtl/record_table_append_search_delete.sv =====
// Top level of the record table: sequencer, record memory and result register.
`timescale 1ns / 1ps

// The table holds up to CAPACITY (part_id, inventory) records in arrival order.
// A request is taken at a rising edge where start is high and busy is low; its
// opcode selects append, search, delete, clear or count, and unused opcodes
// do nothing. Every request produces exactly one result, shown on status,
// found_inventory and record_count for one cycle while done is high. The
// receiver cannot stall, so no result is ever held back.
//
// Append, clear, count and unused opcodes finish in the decode state, whose
// result is registered into done. Search and delete walk the stored
// records through the single read port of the record memory, one record per
// cycle, comparing each key in one shared comparator; the walk ends once the
// last stored record has been compared, or at once for an empty table.
// Delete moves the records after the first match down one slot during the walk.
// Busy stays high until the result is registered, so a new request can be
// taken in the cycle that done is shown.
//
// Reset empties the table at once; the record memory itself is not cleared,
// since only entries below the record count are ever read.

module record_table_append_search_delete
	import rtab_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           opcode,
	input  logic [KEY_W-1:0]     part_id,
	input  logic [VAL_W-1:0]     inventory,
	output logic                 done,
	output logic [1:0]           status,
	output logic [VAL_W-1:0]     found_inventory,
	output logic [CNT_OUT_W-1:0] record_count
);

	// Address width of the record memory, and width of a count that can hold CAPACITY.
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic             accept;
	logic [CW-1:0]    count;
	fin_t             fin;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [REC_W-1:0] mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [REC_W-1:0] mem_rdata;

	logic             done_q;
	status_t          status_q;
	logic [VAL_W-1:0] found_q;

	assign accept = start && !busy;

	rtab_seq #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode),
		.part_id   (part_id),
		.inventory (inventory),
		.busy      (busy),
		.count     (count),
		.fin       (fin),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	rtab_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (REC_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The done strobe is control state; the result fields only load with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.done;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.done) begin
			status_q <= fin.status;
			found_q  <= fin.found_inventory;
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign found_inventory = found_q;
	// The record count register settles at the same edge that loads the result.
	assign record_count    = CNT_OUT_W'(count);

endmodule

// ===== rtl/rtab_mem.sv =====
// Record storage: one write port and one registered read port.
`timescale 1ns / 1ps

module rtab_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rtab_seq.sv =====
// Sequencer: decodes a request and walks the stored records with one key comparator.
`timescale 1ns / 1ps

module rtab_seq
	import rtab_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [2:0]       opcode,
	input  logic [KEY_W-1:0] part_id,
	input  logic [VAL_W-1:0] inventory,
	output logic             busy,
	output logic [CW-1:0]    count,
	output fin_t             fin,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [REC_W-1:0] mem_wdata,
	output logic [AW-1:0]    mem_raddr,
	input  logic [REC_W-1:0] mem_rdata
);

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	state_t           state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    rd_q, rd_d;
	logic             pend_s1, pend_d;
	logic [AW-1:0]    idx_s1, idx_d;
	logic             hit_q, hit_d;
	logic [VAL_W-1:0] hitval_q, hitval_d;
	logic             issue;
	logic             match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(opcode);
			key_q <= part_id;
			val_q <= inventory;
		end
		rd_q     <= rd_d;
		idx_s1   <= idx_d;
		hit_q    <= hit_d;
		hitval_q <= hitval_d;
	end

	assign issue = rd_q < cnt_q;
	assign match = pend_s1 && (mem_rdata[REC_W-1:VAL_W] == key_q);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rd_d      = rd_q;
		pend_d    = 1'b0;
		idx_d     = rd_q[AW-1:0];
		hit_d     = hit_q;
		hitval_d  = hitval_q;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = {key_q, val_q};
		mem_raddr = rd_q[AW-1:0];
		fin       = '{done: 1'b0, status: ST_OK, found_inventory: '0};

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				rd_d  = '0;
				hit_d = 1'b0;
				case (op_q)
					OP_APPEND: begin
						state_d  = S_IDLE;
						fin.done = 1'b1;
						if (cnt_q >= CAP_C) begin
							fin.status = ST_FULL;
						end else begin
							mem_we = 1'b1;
							cnt_d  = cnt_q + ONE_C;
						end
					end
					OP_SEARCH, OP_DELETE: begin
						state_d = S_SCAN;
					end
					OP_CLEAR: begin
						state_d  = S_IDLE;
						fin.done = 1'b1;
						cnt_d    = '0;
					end
					default: begin
						state_d  = S_IDLE;
						fin.done = 1'b1;
					end
				endcase
			end
			S_SCAN: begin
				if (issue) begin
					rd_d   = rd_q + ONE_C;
					pend_d = 1'b1;
				end
				if (op_q == OP_SEARCH) begin
					if (match) begin
						hit_d    = 1'b1;
						hitval_d = mem_rdata[VAL_W-1:0];
					end
				end else begin
					// Once the first match is found, every later record moves down one slot.
					if (pend_s1 && hit_q) begin
						mem_we    = 1'b1;
						mem_waddr = idx_s1 - AW'(1);
						mem_wdata = mem_rdata;
					end else if (match) begin
						hit_d = 1'b1;
					end
				end
				if (!issue && !pend_s1) begin
					state_d    = S_IDLE;
					fin.done   = 1'b1;
					fin.status = hit_q ? ST_OK : ST_MISSING;
					if (op_q == OP_SEARCH) begin
						fin.found_inventory = hit_q ? hitval_q : '0;
					end else if (hit_q) begin
						cnt_d = cnt_q - ONE_C;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy  = state_q != S_IDLE;
	assign count = cnt_q;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the record table: directed, table-full and random request tests.
`timescale 1ns / 1ps

// Every request gets exactly one result. A shadow copy of the table, kept in
// the testbench, works out that result when the request is taken. The result
// goes on the back of a queue. Each strobed result from the block is checked,
// field by field, against the front of that queue.
//
// Requests go through one task. It raises start with the fields and holds
// them until an edge that sees busy low. Between requests the sender may
// idle for a random number of cycles, and the fields change at random while
// start is low. The block cannot be stalled on the result side, so only the
// sender idles.

module tb_top;
	import rtab_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int QUIET_LIMIT = 2000;  // cycles with no request and no result
	localparam int DRAIN_WAIT  = CAPACITY + 16;
	localparam int POOL_SIZE   = 16;

	typedef struct {
		status_t                st;
		logic [VAL_W-1:0]       inv;
		logic [CNT_OUT_W-1:0]   cnt;
	} table_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [2:0]           opcode;
	logic [KEY_W-1:0]     part_id;
	logic [VAL_W-1:0]     inventory;
	logic                 done;
	logic [1:0]           status;
	logic [VAL_W-1:0]     found_inventory;
	logic [CNT_OUT_W-1:0] record_count;

	// Shadow copy of the table contents, in arrival order.
	logic [KEY_W-1:0] shadow_ids [CAPACITY];
	logic [VAL_W-1:0] shadow_vals[CAPACITY];
	int               shadow_count;

	table_result_t    pending_results[$];
	table_result_t    oldest_result;
	int               mismatch_count;
	int               results_seen;
	int               quiet_cycles;
	bit               idle_enable;
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	record_table_append_search_delete #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.part_id        (part_id),
		.inventory      (inventory),
		.done           (done),
		.status         (status),
		.found_inventory(found_inventory),
		.record_count   (record_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Applies one request to the shadow table and returns the result the
	// block should give for it.
	function automatic table_result_t table_apply(logic [2:0] op, logic [KEY_W-1:0] id,
			logic [VAL_W-1:0] inv);
		table_result_t r;
		int            pos;
		bit            hit;
		r.st = ST_OK;
		r.inv = '0;
		pos = -1;
		hit = 1'b0;
		case (op)
			OP_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					// A full table drops the record.
					r.st = ST_FULL;
				end else begin
					shadow_ids[shadow_count] = id;
					shadow_vals[shadow_count] = inv;
					shadow_count++;
				end
			end
			OP_SEARCH: begin
				// Later matches overwrite earlier ones, so the last match wins.
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_ids[i] == id) begin
						hit = 1'b1;
						r.inv = shadow_vals[i];
					end
				end
				if (!hit)
					r.st = ST_MISSING;
			end
			OP_DELETE: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (pos < 0 && shadow_ids[i] == id)
						pos = i;
				end
				if (pos < 0) begin
					r.st = ST_MISSING;
				end else begin
					// Close the gap and keep the order of the records behind it.
					for (int i = pos; i + 1 < shadow_count; i++) begin
						shadow_ids[i] = shadow_ids[i + 1];
						shadow_vals[i] = shadow_vals[i + 1];
					end
					shadow_count--;
				end
			end
			OP_CLEAR: shadow_count = 0;
			OP_COUNT: ;
			default: ;  // unused opcodes leave the table alone
		endcase
		r.cnt = shadow_count[CNT_OUT_W-1:0];
		return r;
	endfunction

	// Prints one line per mismatch and counts all of them.
	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("MISMATCH @%0t result #%0d: %s", $time, results_seen, what);
	endtask

	// Most gaps are short, and a few are long. With idling off, requests
	// follow each other back to back.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_enable || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return KEY_W'($urandom);
	endfunction

	function automatic logic [VAL_W-1:0] pick_inventory();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return VAL_W'($urandom);
	endfunction

	// Replaces some keys of the pool. The extremes stay in the first two slots.
	task automatic refresh_pool(int n);
		for (int i = 0; i < n; i++)
			key_pool[$urandom_range(2, POOL_SIZE - 1)] = KEY_W'($urandom);
	endtask

	// Sends one request and returns at the edge that takes it. Start stays
	// high on return, so a request that follows at once keeps it high.
	task automatic send_request(logic [2:0] op, logic [KEY_W-1:0] id, logic [VAL_W-1:0] inv);
		start <= 1'b1;
		opcode <= op;
		part_id <= id;
		inventory <= inv;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_results.push_back(table_apply(op, id, inv));
	endtask

	// Idles between requests. The fields change while start is low, and
	// the block must ignore them.
	task automatic sender_pause();
		int n;
		n = pick_gap();
		if (n > 0) begin
			start <= 1'b0;
			opcode <= 3'($urandom);
			part_id <= KEY_W'($urandom);
			inventory <= VAL_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_and_pause(logic [2:0] op, logic [KEY_W-1:0] id, logic [VAL_W-1:0] inv);
		send_request(op, id, inv);
		sender_pause();
	endtask

	// Empty-table requests, the field extremes, every opcode, duplicate ids,
	// deleting the only record, and unused opcodes.
	task automatic test_directed();
		idle_enable = 1'b1;
		send_and_pause(OP_COUNT, 16'h0000, 16'h0000);
		send_and_pause(OP_SEARCH, 16'h1234, 16'hFFFF);
		send_and_pause(OP_DELETE, 16'h1234, 16'h0000);
		send_and_pause(OP_APPEND, 16'h0000, 16'hFFFF);
		send_and_pause(OP_DELETE, 16'h0000, 16'h0000);
		send_and_pause(OP_APPEND, 16'h0000, 16'h0000);
		send_and_pause(OP_APPEND, 16'hFFFF, 16'hFFFF);
		send_and_pause(OP_APPEND, 16'h0000, 16'h1111);
		send_and_pause(OP_APPEND, 16'h5A5A, 16'hA5A5);
		send_and_pause(OP_SEARCH, 16'h0000, 16'h0000);
		send_and_pause(OP_SEARCH, 16'hFFFF, 16'h0000);
		send_and_pause(OP_SEARCH, 16'h7777, 16'h0000);
		// The first duplicate goes, and the later one is then found.
		send_and_pause(OP_DELETE, 16'h0000, 16'hFFFF);
		send_and_pause(OP_SEARCH, 16'h0000, 16'h0000);
		send_and_pause(OP_DELETE, 16'h7777, 16'h0000);
		send_and_pause(3'd5, 16'hFFFF, 16'hFFFF);
		send_and_pause(3'd6, 16'h5A5A, 16'h0000);
		send_and_pause(3'd7, 16'h0000, 16'hFFFF);
		send_and_pause(OP_COUNT, 16'hFFFF, 16'hFFFF);
		send_and_pause(OP_CLEAR, 16'h0000, 16'h0000);
		send_and_pause(OP_SEARCH, 16'h0000, 16'h0000);
		send_and_pause(OP_APPEND, 16'hFFFF, 16'h0001);
		send_and_pause(OP_COUNT, 16'h0000, 16'h0000);
	endtask

	// Fills the table to capacity and then works on the full table: dropped
	// appends and full-length scans.
	task automatic test_table_full();
		logic [KEY_W-1:0] last_key;
		idle_enable = 1'b1;
		send_and_pause(OP_CLEAR, pick_key(), pick_inventory());
		for (int i = 0; i < CAPACITY; i++) begin
			last_key = pick_key();
			send_and_pause(OP_APPEND, last_key, pick_inventory());
		end
		for (int i = 0; i < 3; i++)
			send_and_pause(OP_APPEND, pick_key(), pick_inventory());
		send_and_pause(OP_SEARCH, last_key, 16'h0000);
		send_and_pause(OP_SEARCH, KEY_W'($urandom), 16'h0000);
		send_and_pause(OP_COUNT, 16'h0000, 16'h0000);
		send_and_pause(OP_DELETE, last_key, 16'h0000);
		send_and_pause(OP_APPEND, last_key, pick_inventory());
		send_and_pause(OP_APPEND, pick_key(), pick_inventory());
		send_and_pause(OP_DELETE, key_pool[0], 16'h0000);
		send_and_pause(OP_DELETE, key_pool[1], 16'h0000);
	endtask

	// Random requests in phases of 64. A growth phase favors appends and a
	// shrink phase favors deletes, so the record count moves over its whole
	// range. Keys come mostly from a small pool so that searches and deletes
	// hit.
	task automatic test_random(int n_items);
		int               phase;
		int               r;
		int               append_pct;
		logic [2:0]       op;
		for (int k = 0; k < n_items; k++) begin
			if (k % 64 == 0) begin
				phase = $urandom_range(0, 2);
				idle_enable = ($urandom_range(0, 99) < 75);
				refresh_pool(4);
			end
			append_pct = (phase == 0) ? 60 : (phase == 1) ? 15 : 35;
			r = $urandom_range(0, 99);
			if (r < 1)
				op = OP_CLEAR;
			else if (r < 4)
				op = 3'($urandom_range(5, 7));
			else if (r < 8)
				op = OP_COUNT;
			else if (r < 8 + append_pct)
				op = OP_APPEND;
			else if (r < 28 + append_pct)
				op = OP_SEARCH;
			else
				op = OP_DELETE;
			send_and_pause(op, pick_key(), pick_inventory());
		end
	endtask

	// Result checker: each strobed result is compared with the oldest
	// outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: status=%0d inv=%h cnt=%0d",
					status, found_inventory, record_count));
			end else begin
				oldest_result = pending_results.pop_front();
				if (status !== oldest_result.st)
					report_mismatch($sformatf("status %0d, want %0d", status, oldest_result.st));
				if (found_inventory !== oldest_result.inv)
					report_mismatch($sformatf("found_inventory %h, want %h",
						found_inventory, oldest_result.inv));
				if (record_count !== oldest_result.cnt)
					report_mismatch($sformatf("record_count %0d, want %0d",
						record_count, oldest_result.cnt));
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no request
	// taken and no result shown.
	always @(posedge clk) begin
		if (!arst_n || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mismatch_count = 0;
		results_seen = 0;
		quiet_cycles = 0;
		shadow_count = 0;
		idle_enable = 1'b1;
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= '0;
		part_id <= '0;
		inventory <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_random(850);
		start <= 1'b0;

		// Let the last results drain, then look for strays.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
